[hw/rtl/sbsd_pkg.sv]
// ----------------------------------------------------------------------------
// sbsd_pkg
// Shared types and constants for the scaled block-sum downsampler: register
// indexes, command codes, field widths and reset values.
// ----------------------------------------------------------------------------
package sbsd_pkg;

  // Default side of the sample store
  localparam int DEFAULT_MAX_SIDE = 256;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE_LENGTH = 2'd0,
    CFG_OUTPUT_SIDE = 2'd1,
    CFG_SENSITIVITY = 2'd2
  } cfg_idx_t;

  // Register widths and reset values
  localparam int SIDE_REG_W = 9;
  localparam int SENS_W     = 16;
  localparam logic [SIDE_REG_W-1:0] RST_SIDE_LENGTH = 9'd256;
  localparam logic [SIDE_REG_W-1:0] RST_OUTPUT_SIDE = 9'd16;
  localparam logic [SENS_W-1:0]     RST_SENSITIVITY = 16'd1;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Payload widths
  localparam int CELL_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 32;

  // Divisor width of the shared divider (covers sensitivity and output side)
  localparam int DVS_W = 16;

endpackage

[hw/rtl/scaled_block_sum_downsample_unit.sv]
// ----------------------------------------------------------------------------
// scaled_block_sum_downsample_unit
// Stores a square matrix of 16-bit density samples and answers block-sum
// queries. A write transaction (command 0) stores one sample. A query
// transaction (command 1) names an output cell; the block
// works out grain = side / output_side, the wrapped block origin
// (cell * grain mod side) for row and column, then reads grain x grain
// samples, divides each by the sensitivity and adds them with saturation.
// All divisions run on one shared divider that retires one quotient bit per
// cycle, with D = max(8 + clog2(MAX_SIDE+1), 16) steps (17 at MAX_SIDE 256).
// A zero side or zero output side skips the divider and returns 0; a zero
// grain also returns 0. No new transaction is taken while a query runs. The
// result sits in an output register, so writes and the next query can be
// taken while it waits. The sample store has no reset; a query must only
// read samples that were written.
// ----------------------------------------------------------------------------
module scaled_block_sum_downsample_unit #(
  parameter int MAX_SIDE = sbsd_pkg::DEFAULT_MAX_SIDE
) (
  input  logic                           clk,
  input  logic                           rst,
  // input transactions
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           command,
  input  logic [sbsd_pkg::CELL_W-1:0]    row,
  input  logic [sbsd_pkg::CELL_W-1:0]    col,
  input  logic [sbsd_pkg::SAMPLE_W-1:0]  sample_value,
  // result transactions
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [sbsd_pkg::SUM_W-1:0]     cell_sum,
  // configuration writes
  input  logic                           cfg_write_en,
  input  logic [sbsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int IDX_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CMP_W   = (SIDE_W > sbsd_pkg::SIDE_REG_W) ? SIDE_W : sbsd_pkg::SIDE_REG_W;
  localparam int PROD_W  = sbsd_pkg::CELL_W + SIDE_W;
  localparam int DVD_W   = (PROD_W > sbsd_pkg::SAMPLE_W) ? PROD_W : sbsd_pkg::SAMPLE_W;
  localparam int DVS_W   = sbsd_pkg::DVS_W;
  localparam int DEPTH   = 2 ** (2 * IDX_W);
  localparam int SUM_W   = sbsd_pkg::SUM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_GRAIN, S_ROW_MUL, S_ROW_DIV, S_COL_MUL, S_COL_DIV,
    S_SUM_RD, S_SUM_LOAD, S_SUM_DIV, S_FINISH
  } state_t;

  state_t state;

  // Configuration registers
  logic [sbsd_pkg::SIDE_REG_W-1:0] side_length;
  logic [sbsd_pkg::SIDE_REG_W-1:0] output_side;
  logic [sbsd_pkg::SENS_W-1:0]     sensitivity;

  // Query registers
  logic [sbsd_pkg::CELL_W-1:0] cell_row;
  logic [sbsd_pkg::CELL_W-1:0] cell_col;
  logic [SIDE_W-1:0]           grain;
  logic [IDX_W-1:0]            cur_r;
  logic [IDX_W-1:0]            cur_c;
  logic [IDX_W-1:0]            c0;
  logic [IDX_W-1:0]            cnt_i;
  logic [IDX_W-1:0]            cnt_j;
  logic [SUM_W-1:0]            acc;

  // Sample store
  logic [sbsd_pkg::SAMPLE_W-1:0] sample_store [DEPTH];
  logic [sbsd_pkg::SAMPLE_W-1:0] rd_data;
  logic                          mem_we;
  logic [2*IDX_W-1:0]            wr_addr;

  // Shared divider
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;
  logic [DVS_W-1:0] div_rem;

  // Misc combinational
  logic                        accepted;
  logic                        in_range;
  logic                        query_zero;
  logic [SIDE_W-1:0]           side_eff;
  logic [sbsd_pkg::SENS_W-1:0] sens_eff;
  logic [sbsd_pkg::CELL_W-1:0] mul_op;
  logic [PROD_W-1:0]           prod;
  logic [SIDE_W-1:0]           r_inc;
  logic [SIDE_W-1:0]           c_inc;
  logic [IDX_W-1:0]            r_wrap;
  logic [IDX_W-1:0]            c_wrap;
  logic                        i_last;
  logic                        j_last;
  logic [SUM_W:0]              sum_ext;
  logic [SUM_W-1:0]            acc_next;

  assign item_stall = (state != S_IDLE);
  assign accepted   = item_valid && !item_stall;

  // Side clipped to the store, sensitivity of zero taken as one
  assign side_eff = (CMP_W'(side_length) > CMP_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                              : SIDE_W'(side_length);
  assign sens_eff = (sensitivity == '0) ? sbsd_pkg::SENS_W'(1) : sensitivity;

  assign query_zero = (side_eff == '0) || (output_side == '0);

  // Write path
  assign in_range = (CMP_W'(row) < CMP_W'(MAX_SIDE)) && (CMP_W'(col) < CMP_W'(MAX_SIDE));
  assign mem_we   = accepted && (command == sbsd_pkg::CMD_WRITE) && in_range;
  assign wr_addr  = {IDX_W'(row), IDX_W'(col)};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_store[wr_addr] <= sample_value;
    end
    rd_data <= sample_store[{cur_r, cur_c}];
  end

  // Origin multiply: cell index times grain
  assign mul_op = (state == S_ROW_MUL) ? cell_row : cell_col;
  assign prod   = PROD_W'(mul_op) * PROD_W'(grain);

  // Divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DVD_W'(side_eff);
    div_divisor  = DVS_W'(output_side);
    case (state)
      S_IDLE: begin
        div_start = accepted && (command == sbsd_pkg::CMD_QUERY) && !query_zero;
      end
      S_ROW_MUL, S_COL_MUL: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(prod);
        div_divisor  = DVS_W'(side_eff);
      end
      S_SUM_LOAD: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(rd_data);
        div_divisor  = DVS_W'(sens_eff);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  sbsd_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  // Index stepping with wrap at the side
  assign r_inc  = SIDE_W'(cur_r) + SIDE_W'(1);
  assign c_inc  = SIDE_W'(cur_c) + SIDE_W'(1);
  assign r_wrap = (r_inc == side_eff) ? '0 : IDX_W'(r_inc);
  assign c_wrap = (c_inc == side_eff) ? '0 : IDX_W'(c_inc);
  assign i_last = ((SIDE_W'(cnt_i) + SIDE_W'(1)) == grain);
  assign j_last = ((SIDE_W'(cnt_j) + SIDE_W'(1)) == grain);

  // Saturating accumulate of one scaled sample
  assign sum_ext  = {1'b0, acc} + (SUM_W + 1)'(div_quot[sbsd_pkg::SAMPLE_W-1:0]);
  assign acc_next = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      side_length  <= sbsd_pkg::RST_SIDE_LENGTH;
      output_side  <= sbsd_pkg::RST_OUTPUT_SIDE;
      sensitivity  <= sbsd_pkg::RST_SENSITIVITY;
    end else begin
      // configuration writes
      if (cfg_write_en) begin
        case (cfg_index)
          sbsd_pkg::CFG_SIDE_LENGTH: side_length <= cfg_data[sbsd_pkg::SIDE_REG_W-1:0];
          sbsd_pkg::CFG_OUTPUT_SIDE: output_side <= cfg_data[sbsd_pkg::SIDE_REG_W-1:0];
          sbsd_pkg::CFG_SENSITIVITY: sensitivity <= cfg_data;
          default: ;
        endcase
      end

      // result taken, unless a new one loads in its place
      if (result_valid && !result_stall && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accepted && (command == sbsd_pkg::CMD_QUERY)) begin
            cell_row <= row;
            cell_col <= col;
            acc      <= '0;
            state    <= query_zero ? S_FINISH : S_GRAIN;
          end
        end
        S_GRAIN: begin
          if (div_done) begin
            grain <= SIDE_W'(div_quot);
            state <= (div_quot == '0) ? S_FINISH : S_ROW_MUL;
          end
        end
        S_ROW_MUL: begin
          state <= S_ROW_DIV;
        end
        S_ROW_DIV: begin
          if (div_done) begin
            cur_r <= IDX_W'(div_rem);
            state <= S_COL_MUL;
          end
        end
        S_COL_MUL: begin
          state <= S_COL_DIV;
        end
        S_COL_DIV: begin
          if (div_done) begin
            cur_c <= IDX_W'(div_rem);
            c0    <= IDX_W'(div_rem);
            cnt_i <= '0;
            cnt_j <= '0;
            state <= S_SUM_RD;
          end
        end
        S_SUM_RD: begin
          state <= S_SUM_LOAD;
        end
        S_SUM_LOAD: begin
          state <= S_SUM_DIV;
        end
        S_SUM_DIV: begin
          if (div_done) begin
            acc <= acc_next;
            if (j_last) begin
              cnt_j <= '0;
              cur_c <= c0;
              cur_r <= r_wrap;
              cnt_i <= cnt_i + IDX_W'(1);
              state <= i_last ? S_FINISH : S_SUM_RD;
            end else begin
              cnt_j <= cnt_j + IDX_W'(1);
              cur_c <= c_wrap;
              state <= S_SUM_RD;
            end
          end
        end
        S_FINISH: begin
          // wait for the output register to be free
          if (!result_valid || !result_stall) begin
            cell_sum     <= acc;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/sbsd_div.sv]
// ----------------------------------------------------------------------------
// sbsd_div
// Shared restoring divider, one quotient bit per cycle. A start pulse loads
// the operands; done pulses for one cycle once quotient and remainder hold.
// ----------------------------------------------------------------------------
module sbsd_div #(
  parameter int DVD_W = 17,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             fits;
  logic [DVS_W:0]   diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {remainder, quotient[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
        cnt       <= CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        quotient  <= {quotient[DVD_W-2:0], fits};
        remainder <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        cnt       <= cnt - CNT_W'(1);
        done      <= (cnt == CNT_W'(1));
      end
    end
  end

endmodule

[hw/rtl/sbsd_checker.sv]
// ----------------------------------------------------------------------------
// sbsd_checker
// Port-level checks for the block-sum downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module sbsd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_stall,
  input logic                         command,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic [sbsd_pkg::SUM_W-1:0]   cell_sum
);

  // A stalled result stays offered and unchanged
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(cell_sum))
    else $error("stalled result dropped or changed");

  // A sample write does not keep the input side busy
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (command == sbsd_pkg::CMD_WRITE) |=> !item_stall)
    else $error("block busy after a write transaction");

  // A query keeps the input side busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (command == sbsd_pkg::CMD_QUERY) |=> item_stall)
    else $error("input taken while a query is in progress");

  // A new result only appears at the end of a query
  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared without a running query");

endmodule

bind scaled_block_sum_downsample_unit sbsd_checker u_sbsd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .command      (command),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .cell_sum     (cell_sum)
);
